// ===== hw/rtl/mpr_pkg.sv =====
// Shared types, sizes and register codes for the MED predictor residual codec.
package mpr_pkg;

  localparam int MAX_WIDTH    = 4096;
  localparam int MAX_CHANNELS = 4;

  localparam int COL_W       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CMP_W       = 17;
  localparam int CH_LIMIT    = (MAX_CHANNELS < 4) ? MAX_CHANNELS : 4;
  localparam int SAMPLE_W    = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int DEPTH_W     = 5;
  localparam int PLANE_W     = 2;
  localparam int ROW_W       = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [COL_W-1:0]           slot_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

  // Configuration register indexes
  localparam cfg_idx_t REG_DIRECTION = 3'd0;
  localparam cfg_idx_t REG_WIDTH     = 3'd1;
  localparam cfg_idx_t REG_HEIGHT    = 3'd2;
  localparam cfg_idx_t REG_CHANNELS  = 3'd3;
  localparam cfg_idx_t REG_DEPTH0    = 3'd4;
  localparam cfg_idx_t REG_DEPTH1    = 3'd5;
  localparam cfg_idx_t REG_DEPTH2    = 3'd6;
  localparam cfg_idx_t REG_DEPTH3    = 3'd7;

  // One classified sample as it travels from front to back
  typedef struct packed {
    sample_t    sample;
    slot_t      slot;
    logic       has_west;
    logic       has_north;
    logic [3:0] depth_m1;
    logic       end_of_plane;
  } item_t;

endpackage

// ===== hw/rtl/mpr_if.sv =====
// Channel interfaces: sample input, result output and configuration writes.
interface mpr_in_if import mpr_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface mpr_out_if import mpr_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t result;
  logic    end_of_plane;
  modport source (output valid, output result, output end_of_plane, input ready);
  modport sink (input valid, input result, input end_of_plane, output ready);
endinterface

interface mpr_cfg_if import mpr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  cfg_idx_t              index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/mpr_ram.sv =====
// Generic single-write, single-read RAM with registered read (old data on collision).
module mpr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/mpr_front.sv =====
// Front end: configuration registers, raster counters and per-sample classification.
module mpr_front import mpr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  mpr_in_if.sink    in_ch,
  mpr_cfg_if.sink   cfg_ch,
  input  logic      q_full,
  output logic      push,
  output item_t     push_item,
  output logic      direction
);

  logic                dir_r;
  logic [12:0]         width_r;
  logic [ROW_W-1:0]    height_r;
  logic [2:0]          chans_r;
  logic [DEPTH_W-1:0]  depth_r [4];

  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [PLANE_W-1:0]  plane_r, plane_nxt;

  logic [CMP_W-1:0]    width_eff, height_eff, col_inc, row_inc;
  logic [2:0]          chans_eff, plane_inc;
  logic [DEPTH_W-1:0]  depth_sel;
  logic                row_end, plane_end;

  assign in_ch.ready  = !q_full;
  assign cfg_ch.ready = 1'b1;
  assign push         = in_ch.valid && !q_full;
  assign direction    = dir_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r    <= 1'b1;
      width_r  <= 13'd640;
      height_r <= 16'd480;
      chans_r  <= 3'd3;
      for (int i = 0; i < 4; i++) begin
        depth_r[i] <= 5'd8;
      end
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_DIRECTION: dir_r      <= cfg_ch.data[0];
        REG_WIDTH:     width_r    <= cfg_ch.data[12:0];
        REG_HEIGHT:    height_r   <= cfg_ch.data[ROW_W-1:0];
        REG_CHANNELS:  chans_r    <= cfg_ch.data[2:0];
        REG_DEPTH0:    depth_r[0] <= cfg_ch.data[DEPTH_W-1:0];
        REG_DEPTH1:    depth_r[1] <= cfg_ch.data[DEPTH_W-1:0];
        REG_DEPTH2:    depth_r[2] <= cfg_ch.data[DEPTH_W-1:0];
        REG_DEPTH3:    depth_r[3] <= cfg_ch.data[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Geometry limits and end-of-row / end-of-plane detection
  always_comb begin
    if (width_r == 13'd0) begin
      width_eff = CMP_W'(1);
    end else if (CMP_W'(width_r) > CMP_W'(MAX_WIDTH)) begin
      width_eff = CMP_W'(MAX_WIDTH);
    end else begin
      width_eff = CMP_W'(width_r);
    end
    height_eff = (height_r == '0) ? CMP_W'(1) : CMP_W'(height_r);
    if (chans_r == 3'd0) begin
      chans_eff = 3'd1;
    end else if (chans_r > 3'(CH_LIMIT)) begin
      chans_eff = 3'(CH_LIMIT);
    end else begin
      chans_eff = chans_r;
    end
    col_inc   = CMP_W'(col_r) + CMP_W'(1);
    row_inc   = CMP_W'(row_r) + CMP_W'(1);
    plane_inc = 3'(plane_r) + 3'd1;
    row_end   = col_inc >= width_eff;
    plane_end = row_end && (row_inc >= height_eff);
  end

  // Classification of the incoming sample
  always_comb begin
    depth_sel              = depth_r[plane_r];
    push_item.sample       = in_ch.sample;
    push_item.has_west     = col_r != '0;
    push_item.has_north    = row_r != '0;
    push_item.end_of_plane = plane_end;
    if (CMP_W'(col_r) >= CMP_W'(MAX_WIDTH - 1)) begin
      push_item.slot = slot_t'(MAX_WIDTH - 1);
    end else begin
      push_item.slot = col_r;
    end
    if (depth_sel == '0) begin
      push_item.depth_m1 = 4'd0;
    end else if (depth_sel > 5'd16) begin
      push_item.depth_m1 = 4'd15;
    end else begin
      push_item.depth_m1 = 4'(depth_sel - 5'd1);
    end
  end

  // Raster counters advance on each accepted transaction
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    plane_nxt = plane_r;
    if (push) begin
      if (!row_end) begin
        col_nxt = col_r + COL_W'(1);
      end else begin
        col_nxt = '0;
        if (!plane_end) begin
          row_nxt = row_r + ROW_W'(1);
        end else begin
          row_nxt   = '0;
          plane_nxt = (plane_inc >= chans_eff) ? '0 : PLANE_W'(plane_inc);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      plane_r <= '0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      plane_r <= plane_nxt;
    end
  end

endmodule

// ===== hw/rtl/mpr_queue.sv =====
// Short FIFO of classified samples between front and back.
module mpr_queue import mpr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  full,
  output logic  not_empty,
  output item_t head
);

  item_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  count_r, count_nxt;

  assign full      = count_r == QCNT_W'(QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign head      = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/mpr_back.sv =====
// Back end: line buffer, MED prediction, residual wrap and the output register.
module mpr_back import mpr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_not_empty,
  input  item_t      q_head,
  input  logic       direction,
  output logic       pop,
  mpr_out_if.source  out_ch
);

  item_t                x_r;
  logic                 x_valid_r;
  logic                 fwd_r;
  sample_t              fwd_val_r;
  sample_t              west_r, nw_r;
  logic                 out_valid_r;
  sample_t              out_result_r;
  logic                 out_eop_r;

  logic                 fire, load;
  logic [SAMPLE_W-1:0]  ram_rdata;
  sample_t              n, w, nw, pred, res, orig;
  logic signed [17:0]   a, b, c, lo, hi, mid, med;
  logic signed [16:0]   sum;
  logic [15:0]          low, mask;

  assign fire = x_valid_r && (!out_valid_r || out_ch.ready);
  assign load = q_not_empty && (!x_valid_r || fire);
  assign pop  = load;

  // Line buffer: read as a sample enters, write as it retires
  mpr_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (fire),
    .waddr (x_r.slot),
    .wdata (orig),
    .re    (load),
    .raddr (q_head.slot),
    .rdata (ram_rdata)
  );

  // Neighbors and clamped-gradient prediction
  always_comb begin
    if (!x_r.has_north) begin
      n = '0;
    end else if (fwd_r) begin
      n = fwd_val_r;
    end else begin
      n = sample_t'(ram_rdata);
    end
    w   = x_r.has_west ? west_r : '0;
    nw  = (x_r.has_west && x_r.has_north) ? nw_r : '0;
    a   = 18'(n);
    b   = 18'(w);
    c   = a + b - 18'(nw);
    lo  = (a < b) ? a : b;
    hi  = (a > b) ? a : b;
    mid = (hi < c) ? hi : c;
    med = (lo > mid) ? lo : mid;
    pred = sample_t'(med);
  end

  // Forward or inverse step, wrapped to the plane depth
  always_comb begin
    sum  = direction ? (17'(x_r.sample) - 17'(pred)) : (17'(x_r.sample) + 17'(pred));
    low  = sum[15:0];
    mask = 16'hFFFF >> (4'd15 - x_r.depth_m1);
    res  = sample_t'((low & mask) | (low[x_r.depth_m1] ? ~mask : 16'h0000));
    orig = direction ? x_r.sample : res;
  end

  // Working stage and same-slot bypass for back-to-back hits on one column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_valid_r <= 1'b0;
      fwd_r     <= 1'b0;
    end else begin
      if (load) begin
        x_valid_r <= 1'b1;
        fwd_r     <= fire && (q_head.slot == x_r.slot);
      end else if (fire) begin
        x_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_r       <= q_head;
      fwd_val_r <= orig;
    end
  end

  // Neighbor registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      west_r <= '0;
      nw_r   <= '0;
    end else if (fire) begin
      west_r <= orig;
      nw_r   <= n;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_result_r <= res;
      out_eop_r    <= x_r.end_of_plane;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result       = out_result_r;
  assign out_ch.end_of_plane = out_eop_r;

endmodule

// ===== hw/rtl/med_predictor_residual_codec.sv =====
// Top level of the MED predictor residual codec: front, queue and back joined.
//
//  channel  | direction | handshake     | payload
//  ---------+-----------+---------------+-------------------------------
//  in_ch    | in        | valid / ready | sample
//  out_ch   | out       | valid / ready | result, end_of_plane
//  cfg_ch   | in        | valid / ready | index, data (ready always high)
//
// One sample per clock sustained while out_ch.ready holds; a result passes the queue
// slot, the working stage and the output register after its sample is taken.
// The line buffer is a single RAM with one read and one write each cycle;
// a same-column hit on the previous sample is bypassed around it.
// Reset is synchronous; the line buffer is not cleared and needs no sweep.
// A stalled output holds the working stage and fills the two-entry queue,
// after which in_ch.ready drops.
module med_predictor_residual_codec import mpr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  mpr_in_if.sink     in_ch,
  mpr_out_if.source  out_ch,
  mpr_cfg_if.sink    cfg_ch
);

  logic  q_full, q_not_empty, push, pop, direction;
  item_t push_item, q_head;

  mpr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item),
    .direction (direction)
  );

  mpr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  mpr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .direction   (direction),
    .pop         (pop),
    .out_ch      (out_ch)
  );

endmodule
